// File: rtl/core/lgs_pkg.sv
// Shared definitions for the life generation step block: default grid size,
// field widths, item opcodes, controller states and the B3/S23 rule counts.
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int ROW_INDEX_W = 5;
  localparam int ROW_BITS_W  = 32;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: rtl/core/lgs_grid_mem.sv
// Grid row memory: one synchronous (registered) read port and one write port,
// plus a written flag per row so that rows read as dead after reset.
`timescale 1ns / 1ps

module lgs_grid_mem #(
  parameter int GRID_WIDTH  = lgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = lgs_pkg::GRID_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lgs_pkg::mem_ctl_t              ctl,
  input  logic [$clog2(GRID_HEIGHT)-1:0] rd_addr,
  input  logic [$clog2(GRID_HEIGHT)-1:0] wr_addr,
  input  logic [GRID_WIDTH-1:0]          wr_data,
  output logic [GRID_WIDTH-1:0]          rd_data,
  output logic                           rd_vld
);
  import lgs_pkg::*;

  logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] written;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

endmodule

// File: rtl/core/lgs_next_row.sv
// Next-generation logic for one row: counts the eight neighbors of every cell
// from the rows above, at and below it and applies the B3/S23 rule.
`timescale 1ns / 1ps

module lgs_next_row #(
  parameter int GRID_WIDTH = lgs_pkg::GRID_WIDTH_DEF
) (
  input  logic [GRID_WIDTH-1:0] above,
  input  logic [GRID_WIDTH-1:0] mid,
  input  logic [GRID_WIDTH-1:0] below,
  output logic [GRID_WIDTH-1:0] next_row
);
  import lgs_pkg::*;

  logic [GRID_WIDTH-1:0] above_l, above_r, mid_l, mid_r, below_l, below_r;

  assign above_l = above << 1;
  assign above_r = above >> 1;
  assign mid_l   = mid << 1;
  assign mid_r   = mid >> 1;
  assign below_l = below << 1;
  assign below_r = below >> 1;

  always_comb begin
    logic [3:0] n;
    next_row = '0;
    for (int x = 0; x < GRID_WIDTH; x++) begin
      n = {3'b000, above_l[x]} + {3'b000, above[x]} + {3'b000, above_r[x]}
        + {3'b000, mid_l[x]} + {3'b000, mid_r[x]}
        + {3'b000, below_l[x]} + {3'b000, below[x]} + {3'b000, below_r[x]};
      next_row[x] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && mid[x]);
    end
  end

endmodule

// File: rtl/core/life_generation_step.sv
// Conway life (B3/S23) on a GRID_WIDTH by GRID_HEIGHT grid held one row per word
// in a single memory. A step item scans the grid once through the memory's single
// read port, keeping a three-row window, and writes each new row back in place
// as it is emitted. Inputs are stalled while a read or a step is in progress.
`timescale 1ns / 1ps

module life_generation_step #(
  parameter int GRID_WIDTH  = lgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = lgs_pkg::GRID_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [lgs_pkg::ROW_INDEX_W-1:0] row_index,
  input  logic [lgs_pkg::ROW_BITS_W-1:0]  row_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lgs_pkg::ROW_INDEX_W-1:0] row_index_res,
  output logic [lgs_pkg::ROW_BITS_W-1:0]  row_bits_res,
  output logic                            last
);
  import lgs_pkg::*;

  localparam int AW = $clog2(GRID_HEIGHT);
  localparam int CW = $clog2(GRID_HEIGHT + 2);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_H    = CW'(GRID_HEIGHT);
  localparam logic [CW-1:0] CNT_LAST = CW'(GRID_HEIGHT + 1);

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [GRID_WIDTH-1:0] prev2, prev1, cur_row, new_row;
  logic [ROW_INDEX_W-1:0] rd_idx;
  logic rd_inr;

  mem_ctl_t mem_ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [GRID_WIDTH-1:0] wr_data, rd_data;
  logic rd_vld;

  logic accept, out_free, in_range, adv, load_read, load_step;

  lgs_grid_mem #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data),
    .rd_vld (rd_vld)
  );

  lgs_next_row #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_rule (
    .above   (prev2),
    .mid     (prev1),
    .below   (cur_row),
    .next_row(new_row)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = ({2'b00, row_index} < 7'(GRID_HEIGHT));
  assign adv      = (state == ST_STEP) && out_free;
  assign cur_row  = ((cnt != CNT_LAST) && rd_vld) ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    rd_addr    = '0;
    wr_addr    = '0;
    wr_data    = '0;
    load_read  = 1'b0;
    load_step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_WRITE: begin
              mem_ctl.wr_en = in_range;
              wr_addr       = AW'(row_index);
              wr_data       = GRID_WIDTH'(row_bits);
            end
            OP_READ: begin
              mem_ctl.rd_en = in_range;
              rd_addr       = AW'(row_index);
              state_next    = ST_READ;
            end
            OP_STEP: begin
              state_next = ST_STEP;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_read  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (adv) begin
          mem_ctl.rd_en = (cnt < CNT_H);
          rd_addr       = AW'(cnt);
          if (cnt >= CNT_TWO) begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = AW'(cnt - CNT_TWO);
            wr_data       = new_row;
            load_step     = 1'b1;
          end
          if (cnt == CNT_LAST) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= '0;
      end else if (adv) begin
        cnt <= cnt + 1'b1;
      end
      if (load_read || load_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev2  <= '0;
      prev1  <= '0;
      rd_idx <= row_index;
      rd_inr <= in_range;
    end else if (adv && (cnt != '0)) begin
      prev2 <= prev1;
      prev1 <= cur_row;
    end
    if (load_read) begin
      row_index_res <= rd_idx;
      row_bits_res  <= (rd_inr && rd_vld) ? ROW_BITS_W'(rd_data) : '0;
      last          <= 1'b1;
    end else if (load_step) begin
      row_index_res <= ROW_INDEX_W'(cnt - CNT_TWO);
      row_bits_res  <= ROW_BITS_W'(new_row);
      last          <= (cnt == CNT_LAST);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (adv && (cnt == CNT_LAST)) |=> (state == ST_IDLE) && out_valid && last)
    else $error("step did not finish with a marked final row");

  assert property (@(posedge clk) disable iff (rst)
    (adv && (cnt >= CNT_TWO) && (cnt <= CNT_H)) |=> out_valid && !last)
    else $error("intermediate step row missing or marked final");

  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_READ) && out_free) |=> out_valid && last && (state == ST_IDLE))
    else $error("read result not delivered as a single final item");

endmodule
